/* rtl/core/tsp_pkg.sv */
// Shared types and constants of the tile ring seam planner.
`timescale 1ns / 1ps

package tsp_pkg;

    localparam int POS_W      = 12;  // camera tile coordinate
    localparam int IDX_W      = 14;  // signed map index of a strip
    localparam int SLOT_W     = 6;   // ring slot
    localparam int CNT_W      = 6;   // strips left on one axis, up to 63
    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 40;

    localparam logic KIND_COL = 1'b0;
    localparam logic KIND_ROW = 1'b1;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic red_step;
        logic red_final;   // 0: quotient step, 1: remainder step
        logic emit_col;
        logic emit_row;
    } tsp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic col_left_zero;
        logic col_left_one;
        logic row_left_zero;
        logic row_left_one;
    } tsp_status_t;

endpackage

/* rtl/core/tsp_datapath.sv */
// Datapath of the seam planner: strip ranges, slot reduction and output register.
`timescale 1ns / 1ps

module tsp_datapath #(
    parameter int RING_COLS     = 24,
    parameter int RING_ROWS     = 16,
    parameter int WINDOW_MARGIN = 2,
    parameter int RED_W         = 13
) (
    input  logic                            aclk,
    input  logic [tsp_pkg::IN_DATA_W-1:0]   in_data,
    input  tsp_pkg::tsp_cmd_t               cmd,
    output tsp_pkg::tsp_status_t            status,
    output logic [tsp_pkg::OUT_DATA_W-1:0]  out_data,
    output logic                            out_kind,
    output logic                            out_last
);

    localparam int IW = tsp_pkg::IDX_W;
    localparam int PW = tsp_pkg::POS_W;
    localparam int CW = tsp_pkg::CNT_W;
    localparam int SW = tsp_pkg::SLOT_W;
    // reciprocal scale: exact quotient for every RED_W-bit operand and ring sizes below 64
    localparam int RED_SH     = RED_W + SW;
    localparam int RECIP_COLS = ((1 << RED_SH) + RING_COLS - 1) / RING_COLS;
    localparam int RECIP_ROWS = ((1 << RED_SH) + RING_ROWS - 1) / RING_ROWS;

    logic [PW-1:0] old_col, old_row, new_col, new_row;
    logic [IW-1:0] d_col, d_row, base_col, base_row, first_col, first_row;
    logic [IW-1:0] cross_row, cross_col;
    logic [PW-1:0] dist_col, dist_row;
    logic [CW-1:0] cnt_col, cnt_row;

    logic [IW-1:0]    col_idx_reg, row_idx_reg, cross_row_reg, cross_col_reg;
    logic [CW-1:0]    col_left_reg, row_left_reg;
    logic [RED_W-1:0] lane_col_reg, lane_row_reg, lane_xrow_reg, lane_xcol_reg;
    logic [RED_W-1:0] quot_col_reg, quot_row_reg, quot_xrow_reg, quot_xcol_reg;
    logic [tsp_pkg::OUT_DATA_W-1:0] out_data_reg;
    logic             out_kind_reg, out_last_reg;

    // quotient by the ring size through its scaled reciprocal
    function automatic logic [RED_W-1:0] red_quot(
        input logic [RED_W-1:0]  v,
        input logic [RED_SH-1:0] recip
    );
        logic [RED_W+RED_SH-1:0] prod;
        prod     = {{RED_SH{1'b0}}, v} * {{RED_W{1'b0}}, recip};
        red_quot = prod[RED_W+RED_SH-1:RED_SH];
    endfunction

    // remainder from the operand and its quotient
    function automatic logic [RED_W-1:0] red_rem(
        input logic [RED_W-1:0] v,
        input logic [RED_W-1:0] q,
        input logic [SW-1:0]    m
    );
        logic [RED_W-1:0] qm;
        qm      = q * {{(RED_W-SW){1'b0}}, m};
        red_rem = v - qm;
    endfunction

    function automatic logic [RED_W-1:0] slot_inc(
        input logic [RED_W-1:0] v,
        input logic [SW-1:0]    m
    );
        if (v == RED_W'(m - SW'(1))) begin
            slot_inc = '0;
        end else begin
            slot_inc = v + RED_W'(1);
        end
    endfunction

    assign old_col = in_data[PW-1:0];
    assign old_row = in_data[2*PW-1:PW];
    assign new_col = in_data[3*PW-1:2*PW];
    assign new_row = in_data[4*PW-1:3*PW];

    always_comb begin
        d_col    = {2'b00, new_col} - {2'b00, old_col};
        d_row    = {2'b00, new_row} - {2'b00, old_row};
        dist_col = d_col[IW-1] ? PW'(-d_col) : d_col[PW-1:0];
        dist_row = d_row[IW-1] ? PW'(-d_row) : d_row[PW-1:0];
        cnt_col  = (dist_col > PW'(RING_COLS)) ? CW'(RING_COLS) : dist_col[CW-1:0];
        cnt_row  = (dist_row > PW'(RING_ROWS)) ? CW'(RING_ROWS) : dist_row[CW-1:0];
        // forward move: strips end at the new far edge; backward: start at new origin
        base_col = d_col[IW-1] ? ({2'b00, old_col} - IW'(WINDOW_MARGIN))
                               : ({2'b00, new_col} + IW'(RING_COLS) - IW'(WINDOW_MARGIN));
        base_row = d_row[IW-1] ? ({2'b00, old_row} - IW'(WINDOW_MARGIN))
                               : ({2'b00, new_row} + IW'(RING_ROWS) - IW'(WINDOW_MARGIN));
        first_col = base_col - {{(IW-CW){1'b0}}, cnt_col};
        first_row = base_row - {{(IW-CW){1'b0}}, cnt_row};
        cross_row = {2'b00, new_row} - IW'(WINDOW_MARGIN);
        cross_col = {2'b00, new_col} - IW'(WINDOW_MARGIN);
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            col_idx_reg   <= first_col;
            row_idx_reg   <= first_row;
            cross_row_reg <= cross_row;
            cross_col_reg <= cross_col;
            col_left_reg  <= cnt_col;
            row_left_reg  <= cnt_row;
            // bias by a multiple of the ring size so the operand is never negative
            lane_col_reg  <= RED_W'(first_col + IW'(RING_COLS * WINDOW_MARGIN));
            lane_row_reg  <= RED_W'(first_row + IW'(RING_ROWS * WINDOW_MARGIN));
            lane_xrow_reg <= RED_W'(cross_row + IW'(RING_ROWS * WINDOW_MARGIN));
            lane_xcol_reg <= RED_W'(cross_col + IW'(RING_COLS * WINDOW_MARGIN));
        end else if (cmd.red_step) begin
            if (!cmd.red_final) begin
                quot_col_reg  <= red_quot(lane_col_reg,  RED_SH'(RECIP_COLS));
                quot_row_reg  <= red_quot(lane_row_reg,  RED_SH'(RECIP_ROWS));
                quot_xrow_reg <= red_quot(lane_xrow_reg, RED_SH'(RECIP_ROWS));
                quot_xcol_reg <= red_quot(lane_xcol_reg, RED_SH'(RECIP_COLS));
            end else begin
                lane_col_reg  <= red_rem(lane_col_reg,  quot_col_reg,  SW'(RING_COLS));
                lane_row_reg  <= red_rem(lane_row_reg,  quot_row_reg,  SW'(RING_ROWS));
                lane_xrow_reg <= red_rem(lane_xrow_reg, quot_xrow_reg, SW'(RING_ROWS));
                lane_xcol_reg <= red_rem(lane_xcol_reg, quot_xcol_reg, SW'(RING_COLS));
            end
        end else if (cmd.emit_col) begin
            out_data_reg <= {lane_xrow_reg[SW-1:0], cross_row_reg,
                             lane_col_reg[SW-1:0], col_idx_reg};
            out_kind_reg <= tsp_pkg::KIND_COL;
            out_last_reg <= (col_left_reg == CW'(1)) && (row_left_reg == '0);
            col_idx_reg  <= col_idx_reg + IW'(1);
            col_left_reg <= col_left_reg - CW'(1);
            lane_col_reg <= slot_inc(lane_col_reg, SW'(RING_COLS));
        end else if (cmd.emit_row) begin
            out_data_reg <= {lane_xcol_reg[SW-1:0], cross_col_reg,
                             lane_row_reg[SW-1:0], row_idx_reg};
            out_kind_reg <= tsp_pkg::KIND_ROW;
            out_last_reg <= (row_left_reg == CW'(1));
            row_idx_reg  <= row_idx_reg + IW'(1);
            row_left_reg <= row_left_reg - CW'(1);
            lane_row_reg <= slot_inc(lane_row_reg, SW'(RING_ROWS));
        end
    end

    assign status.col_left_zero = (col_left_reg == '0);
    assign status.col_left_one  = (col_left_reg == CW'(1));
    assign status.row_left_zero = (row_left_reg == '0);
    assign status.row_left_one  = (row_left_reg == CW'(1));

    assign out_data = out_data_reg;
    assign out_kind = out_kind_reg;
    assign out_last = out_last_reg;

endmodule

/* rtl/core/tsp_ctrl.sv */
// Controller of the seam planner: request sequencing and output handshake.
`timescale 1ns / 1ps

module tsp_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    input  tsp_pkg::tsp_status_t status,
    output tsp_pkg::tsp_cmd_t    cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_EMIT_COL,
        ST_EMIT_ROW
    } state_t;

    state_t state_reg;
    logic   step_reg;
    logic   m_tvalid_reg;
    logic   out_free;

    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;

    always_comb begin
        cmd.load      = (state_reg == ST_IDLE) && s_tvalid;
        cmd.red_step  = (state_reg == ST_REDUCE);
        cmd.red_final = step_reg;
        cmd.emit_col  = (state_reg == ST_EMIT_COL) && out_free;
        cmd.emit_row  = (state_reg == ST_EMIT_ROW) && out_free;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            step_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cmd.emit_col || cmd.emit_row) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        state_reg <= ST_REDUCE;
                        step_reg  <= 1'b0;
                    end
                end
                ST_REDUCE: begin
                    if (step_reg) begin
                        if (!status.col_left_zero) begin
                            state_reg <= ST_EMIT_COL;
                        end else if (!status.row_left_zero) begin
                            state_reg <= ST_EMIT_ROW;
                        end else begin
                            state_reg <= ST_IDLE;
                        end
                    end else begin
                        step_reg <= 1'b1;
                    end
                end
                ST_EMIT_COL: begin
                    if (out_free && status.col_left_one) begin
                        state_reg <= status.row_left_zero ? ST_IDLE : ST_EMIT_ROW;
                    end
                end
                ST_EMIT_ROW: begin
                    if (out_free && status.row_left_one) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

/* rtl/core/tile_ring_seam_planner_core.sv */
// Top level of the tile ring seam planner: controller, datapath and checks.
`timescale 1ns / 1ps
//
// Usage: each request on the s_ channel carries the old and the new camera
// tile position. For it the block emits, on the m_ channel, one strip per
// column that has newly entered the loaded window (increasing map column),
// then one per newly entered row (increasing map row). Each axis is clamped
// to one ring's worth of strips. m_tuser gives the strip kind, m_tlast marks
// the final strip of the move. A request that does not move the camera gives
// no strips.
// Timing: a request is taken only while the block is idle. The ring slots of
// the first strip and of the window origin are found by a reciprocal
// multiplication in two steps, one for the quotient and one for the
// remainder; the strips then follow one per cycle while the receiver takes
// them.
// Reset: aresetn low at a clock edge returns the sequencer to idle and drops
// m_tvalid. A stalled receiver holds the current strip in the output
// register and pauses the sequencer; the next request is accepted as soon as
// the last strip is in the output register, even while it waits.

module tile_ring_seam_planner_core #(
    parameter int RING_COLS     = 24,
    parameter int RING_ROWS     = 16,
    parameter int WINDOW_MARGIN = 2
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // old_col, old_row, new_col, new_row (12 bits each)
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // strip_index, strip_slot, span_first, span_first_slot
    output logic [0:0]  m_tuser,   // strip_kind
    output logic        m_tlast    // is_last
);

    localparam int RING_MAX = (RING_COLS > RING_ROWS) ? RING_COLS : RING_ROWS;
    // reduction operand width: largest index plus the non-negative bias
    localparam int RED_W = $clog2(4096 + RING_MAX * (WINDOW_MARGIN + 1));

    tsp_pkg::tsp_cmd_t    cmd;
    tsp_pkg::tsp_status_t status;
    logic                 out_kind;

    tsp_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .status  (status),
        .cmd     (cmd)
    );

    tsp_datapath #(
        .RING_COLS    (RING_COLS),
        .RING_ROWS    (RING_ROWS),
        .WINDOW_MARGIN(WINDOW_MARGIN),
        .RED_W        (RED_W)
    ) u_datapath (
        .aclk    (aclk),
        .in_data (s_tdata),
        .cmd     (cmd),
        .status  (status),
        .out_data(m_tdata),
        .out_kind(out_kind),
        .out_last(m_tlast)
    );

    assign m_tuser = out_kind;

    // one request at a time: acceptance is followed by a busy cycle
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request accepted while a move is still in progress");

    // a new strip never overwrites one the receiver has not taken
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.emit_col || cmd.emit_row) |-> (!m_tvalid || m_tready))
        else $error("output register overwritten while stalled");

    // strips are emitted only while no request is being taken
    a_emit_not_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.emit_col || cmd.emit_row) |-> !s_tready && !cmd.red_step)
        else $error("strip emitted outside the emission phase");

    // a column strip never follows a row strip of the same move
    a_col_before_row: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit_row |=> !cmd.emit_col)
        else $error("column strip issued after a row strip");

endmodule

/* tb/sv/testbench.sv */
// Self-checking testbench for the tile ring seam planner core.
`timescale 1ns / 1ps

// Camera moves go in on the s_ channel. For each accepted move the expected
// column and row strips are worked out from the camera positions, using a
// wrapping window with a fixed margin, and queued. Every strip on the m_
// channel is compared field by field with the oldest expected strip.
// The sender works in random bursts. Twice it waits until every strip has
// come out. The receiver stalls on a changing pattern, and once holds off for
// a long stretch so that the block fills up and stops taking requests.
module testbench;

    localparam int COLS   = 24;
    localparam int ROWS   = 16;
    localparam int MARGIN = 2;
    localparam int MAX_POS = (1 << tsp_pkg::POS_W) - 1;
    localparam int N_RANDOM = 440;
    localparam int LONG_HOLD = 300;
    localparam int HOLD_AFTER = 120;   // accepted requests before the long hold-off
    localparam int SETTLE_CYCLES = 64;

    // one request: packed so that old_col sits in the lowest bits of s_tdata
    typedef struct packed {
        logic [tsp_pkg::POS_W-1:0] new_row;
        logic [tsp_pkg::POS_W-1:0] new_col;
        logic [tsp_pkg::POS_W-1:0] old_row;
        logic [tsp_pkg::POS_W-1:0] old_col;
    } move_t;

    typedef struct {
        logic                             kind;
        logic signed [tsp_pkg::IDX_W-1:0] index;
        logic [tsp_pkg::SLOT_W-1:0]       slot;
        logic signed [tsp_pkg::IDX_W-1:0] span;
        logic [tsp_pkg::SLOT_W-1:0]       span_slot;
        logic                             last;
    } strip_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic [0:0]  m_tuser;
    logic        m_tlast;

    move_t  move_q[$];     // moves not yet offered
    strip_t seam_q[$];     // strips still owed by the block
    move_t  cur_move;      // move currently on s_tdata

    int fail_cnt = 0;
    int offered_cnt = 0;
    int accepted_cnt = 0;
    int burst_left = 0;
    int gap_left = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;
    int rx_mode = 0;
    int rx_mode_left = 0;

    tile_ring_seam_planner_core #(
        .RING_COLS    (COLS),
        .RING_ROWS    (ROWS),
        .WINDOW_MARGIN(MARGIN)
    ) u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Non-negative remainder: the window may start below map index zero.
    function automatic int wrap_slot(input int v, input int m);
        int r;
        r = v % m;
        return (r < 0) ? r + m : r;
    endfunction

    // Range of map indices newly entering the window on one axis; empty when
    // the camera did not move. Clamp a wide move to the last ring's worth.
    function automatic void entering_range(input int oldp, input int newp, input int size,
                                           output int first, output int last_i);
        first  = 0;
        last_i = -1;
        if (newp > oldp) begin
            first  = oldp - MARGIN + size;
            last_i = newp - MARGIN + size - 1;
        end else if (newp < oldp) begin
            first  = newp - MARGIN;
            last_i = oldp - MARGIN - 1;
        end
        if (last_i - first >= size)
            first = last_i - size + 1;
    endfunction

    // Queue the strips that a move uncovers: columns first, then rows.
    function automatic void plan_seams(input move_t mv);
        int     c_first, c_last, r_first, r_last;
        int     total, k, col0, row0;
        strip_t s;
        entering_range(mv.old_col, mv.new_col, COLS, c_first, c_last);
        entering_range(mv.old_row, mv.new_row, ROWS, r_first, r_last);
        total = (c_last - c_first + 1) + (r_last - r_first + 1);
        col0  = int'(mv.new_col) - MARGIN;
        row0  = int'(mv.new_row) - MARGIN;
        k     = 0;
        for (int i = c_first; i <= c_last; i++) begin
            s.kind      = tsp_pkg::KIND_COL;
            s.index     = i[tsp_pkg::IDX_W-1:0];
            s.slot      = tsp_pkg::SLOT_W'(wrap_slot(i, COLS));
            s.span      = row0[tsp_pkg::IDX_W-1:0];
            s.span_slot = tsp_pkg::SLOT_W'(wrap_slot(row0, ROWS));
            k++;
            s.last      = (k == total);
            seam_q.push_back(s);
        end
        for (int i = r_first; i <= r_last; i++) begin
            s.kind      = tsp_pkg::KIND_ROW;
            s.index     = i[tsp_pkg::IDX_W-1:0];
            s.slot      = tsp_pkg::SLOT_W'(wrap_slot(i, ROWS));
            s.span      = col0[tsp_pkg::IDX_W-1:0];
            s.span_slot = tsp_pkg::SLOT_W'(wrap_slot(col0, COLS));
            k++;
            s.last      = (k == total);
            seam_q.push_back(s);
        end
    endfunction

    function automatic logic [tsp_pkg::POS_W-1:0] nudge(input int base, input int delta);
        int v;
        v = base + delta;
        if (v < 0)
            v = 0;
        if (v > MAX_POS)
            v = MAX_POS;
        return v[tsp_pkg::POS_W-1:0];
    endfunction

    function automatic move_t mk_move(input int oc, input int orow, input int nc, input int nr);
        move_t mv;
        mv.old_col = oc[tsp_pkg::POS_W-1:0];
        mv.old_row = orow[tsp_pkg::POS_W-1:0];
        mv.new_col = nc[tsp_pkg::POS_W-1:0];
        mv.new_row = nr[tsp_pkg::POS_W-1:0];
        return mv;
    endfunction

    // Sender: hold a request until it is taken, then decide on the next one.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!(s_tvalid && !s_tready)) begin
            if (s_tvalid) begin
                plan_seams(cur_move);
                accepted_cnt <= accepted_cnt + 1;
            end
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                s_tvalid <= 1'b0;
            end else if ((offered_cnt == 25 || offered_cnt == 260) && seam_q.size() != 0) begin
                // drain: wait for every owed strip before going on
                s_tvalid <= 1'b0;
            end else if (move_q.size() != 0) begin
                cur_move = move_q.pop_front();
                s_tdata     <= cur_move;
                s_tvalid    <= 1'b1;
                offered_cnt <= offered_cnt + 1;
                if (burst_left <= 1) begin
                    if ($urandom_range(0, 3) == 0) begin
                        burst_left <= 30;
                        gap_left   <= 0;
                    end else begin
                        burst_left <= $urandom_range(1, 8);
                        gap_left   <= $urandom_range(0, 40);
                    end
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: switch stall pattern now and then; one long hold-off.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else if (!hold_done && accepted_cnt >= HOLD_AFTER) begin
            hold_done <= 1'b1;
            hold_left <= LONG_HOLD;
            m_tready  <= 1'b0;
        end else begin
            if (rx_mode_left == 0) begin
                rx_mode      <= $urandom_range(0, 3);
                rx_mode_left <= $urandom_range(16, 96);
            end else begin
                rx_mode_left <= rx_mode_left - 1;
            end
            case (rx_mode)
                0: begin
                    m_tready <= 1'b1;
                end
                1: begin
                    m_tready <= ($urandom_range(0, 3) != 0);
                end
                2: begin
                    m_tready <= ($urandom_range(0, 3) == 0);
                end
                default: begin
                    m_tready <= ~m_tready;
                end
            endcase
        end
    end

    // Compare every strip taken with the oldest one owed.
    always @(posedge aclk) begin
        strip_t exp_s;
        if (aresetn && m_tvalid && m_tready) begin
            if (seam_q.size() == 0) begin
                $error("strip with none owed: tdata %h tuser %b tlast %b",
                       m_tdata, m_tuser, m_tlast);
                fail_cnt++;
            end else begin
                exp_s = seam_q.pop_front();
                if (m_tuser[0] !== exp_s.kind) begin
                    $error("strip_kind expected %0d got %0d", exp_s.kind, m_tuser[0]);
                    fail_cnt++;
                end
                if (m_tdata[13:0] !== exp_s.index) begin
                    $error("strip_index expected %0d got %0d", exp_s.index,
                           $signed(m_tdata[13:0]));
                    fail_cnt++;
                end
                if (m_tdata[19:14] !== exp_s.slot) begin
                    $error("strip_slot expected %0d got %0d", exp_s.slot, m_tdata[19:14]);
                    fail_cnt++;
                end
                if (m_tdata[33:20] !== exp_s.span) begin
                    $error("span_first expected %0d got %0d", exp_s.span,
                           $signed(m_tdata[33:20]));
                    fail_cnt++;
                end
                if (m_tdata[39:34] !== exp_s.span_slot) begin
                    $error("span_first_slot expected %0d got %0d", exp_s.span_slot,
                           m_tdata[39:34]);
                    fail_cnt++;
                end
                if (m_tlast !== exp_s.last) begin
                    $error("is_last expected %0d got %0d", exp_s.last, m_tlast);
                    fail_cnt++;
                end
            end
        end
    end

    initial begin
        int sel, oc, orow, nc, nr;

        // directed moves
        move_q.push_back(mk_move(100, 100, 100, 100));      // no move
        move_q.push_back(mk_move(0, 0, 0, 0));
        move_q.push_back(mk_move(MAX_POS, MAX_POS, MAX_POS, MAX_POS));
        move_q.push_back(mk_move(100, 50, 101, 50));        // one column right
        move_q.push_back(mk_move(100, 50, 99, 50));         // one column left
        move_q.push_back(mk_move(100, 50, 100, 51));        // one row down
        move_q.push_back(mk_move(100, 50, 100, 49));        // one row up
        move_q.push_back(mk_move(200, 300, 201, 301));      // both axes
        move_q.push_back(mk_move(200, 300, 197, 302));
        move_q.push_back(mk_move(500, 500, 524, 500));      // exactly one ring wide
        move_q.push_back(mk_move(500, 500, 525, 500));      // clamped
        move_q.push_back(mk_move(500, 500, 500, 516));
        move_q.push_back(mk_move(500, 500, 500, 483));
        move_q.push_back(mk_move(0, 7, MAX_POS, 7));        // widest moves
        move_q.push_back(mk_move(MAX_POS, 7, 0, 7));
        move_q.push_back(mk_move(9, 0, 9, MAX_POS));
        move_q.push_back(mk_move(9, MAX_POS, 9, 0));
        move_q.push_back(mk_move(0, 0, MAX_POS, MAX_POS));  // most strips
        move_q.push_back(mk_move(MAX_POS, MAX_POS, 0, 0));
        move_q.push_back(mk_move(1, 1, 0, 0));              // window below zero
        move_q.push_back(mk_move(3, 2, 0, 1));
        move_q.push_back(mk_move('hAAA, 'h555, 'h555, 'hAAA));
        move_q.push_back(mk_move('h555, 'hAAA, 'hAAA, 'h555));

        // random moves: mostly short scrolls, some jumps and some standing still
        repeat (N_RANDOM) begin
            sel  = $urandom_range(0, 99);
            oc   = $urandom_range(0, MAX_POS);
            orow = $urandom_range(0, MAX_POS);
            if (sel < 55) begin
                nc = nudge(oc, $urandom_range(0, 6) - 3);
                nr = nudge(orow, $urandom_range(0, 6) - 3);
            end else if (sel < 70) begin
                nc = nudge(oc, $urandom_range(0, 60) - 30);
                nr = nudge(orow, $urandom_range(0, 40) - 20);
            end else if (sel < 82) begin
                nc = $urandom_range(0, MAX_POS);
                nr = $urandom_range(0, MAX_POS);
            end else if (sel < 90) begin
                nc = oc;
                nr = orow;
            end else begin
                // scroll about near the map edges
                oc   = ($urandom_range(0, 1) != 0) ? $urandom_range(0, 6)
                                                   : MAX_POS - $urandom_range(0, 6);
                orow = ($urandom_range(0, 1) != 0) ? $urandom_range(0, 6)
                                                   : MAX_POS - $urandom_range(0, 6);
                nc   = nudge(oc, $urandom_range(0, 10) - 5);
                nr   = nudge(orow, $urandom_range(0, 10) - 5);
            end
            move_q.push_back(mk_move(oc, orow, nc, nr));
        end

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        while (move_q.size() != 0 || s_tvalid || seam_q.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);

        if (fail_cnt == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // guard against a hung handshake
    initial begin
        #2000000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

/* files.f */
rtl/core/tsp_pkg.sv
rtl/core/tsp_datapath.sv
rtl/core/tsp_ctrl.sv
rtl/core/tile_ring_seam_planner_core.sv
tb/sv/testbench.sv
